// ----- design/qrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver: payload structs,
// root count codes, equation classes and the fixed datapath widths.
// ----------------------------------------------------------------------------
package qrs_pkg;

    // Default number of fractional bits of the Q format.
    localparam int FRAC_BITS_DEF = 16;

    // Square root result bits: the discriminant stays below 2^66.
    localparam int SQ_STEPS = 35;
    // Discriminant padded to an even number of bits for the root digits.
    localparam int DISC_W = 2 * SQ_STEPS;
    // Partial remainder width of the square root.
    localparam int SQ_REM_W = 39;
    // Quotient bits produced by the long division.
    localparam int Q_BITS = 34;
    // Numerator and denominator magnitude widths.
    localparam int NMAG_W = 35;
    localparam int DMAG_W = 33;

    // Input transfer.
    typedef struct packed {
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
    } coef_t;

    // Result transfer.
    typedef struct packed {
        logic [1:0]         root_count;
        logic signed [31:0] first_root;
        logic signed [31:0] second_root;
        logic               overflow;
    } result_t;

    // Root count codes.
    typedef enum logic [1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2,
        CNT_ANY  = 2'd3
    } count_t;

    // Equation class decided once the discriminant is known.
    typedef enum logic [2:0] {
        CL_NONE,
        CL_ANY,
        CL_LIN,
        CL_ONE,
        CL_TWO
    } class_t;

    // Side data carried along the square root stages.
    typedef struct packed {
        class_t      cls;
        logic        an;
        logic        bn;
        logic        cn;
        logic [31:0] am;
        logic [31:0] bm;
        logic [31:0] cm;
    } sq_meta_t;

endpackage
`default_nettype wire

// ----- design/quadratic_root_solver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 for signed fixed-point coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   A coefficient triple on coef is transferred at a rising edge where start
//   is high and busy is low. busy is always low: a new triple may be sent in
//   every cycle. Each triple gives exactly one result on result, shown for
//   one cycle with done high, in the order the triples arrived.
// Pipeline: input, multiply and discriminant registers, the 35 digit stages
//   of the square root, the divider setup register, the 34 quotient stages
//   of the divider and the output register, in that order.
// Throughput: one triple per cycle.
// Reset: rst_n clears every stage valid bit, so no result is in flight.
// The receiver cannot stall; each result is taken in its done cycle.
// Roots outside the Q range saturate and raise overflow.
// ----------------------------------------------------------------------------
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  coef_t   coef,
    output logic    done,
    output result_t result
);

    // Dividend width and the part above the quotient bits.
    localparam int NW = NMAG_W + FRAC_BITS;
    localparam int HW = NW - Q_BITS;

    // Saturate a truncated quotient; returns {overflow, value}.
    function automatic logic [32:0] sat_root(input logic neg, input logic pov,
                                             input logic [Q_BITS-1:0] q);
        logic [32:0] r;
        if (pov || (!neg && q > 34'h07FFFFFFF) || (neg && q > 34'h080000000))
        begin
            r = {1'b1, (neg ? 32'h80000000 : 32'h7FFFFFFF)};
        end
        else
        begin
            r = {1'b0, (neg ? (~q[31:0] + 32'd1) : q[31:0])};
        end
        return r;
    endfunction

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage A: signs and magnitudes of the coefficients.
    // ------------------------------------------------------------------
    logic        a_valid_reg;
    logic        a_an_reg, a_bn_reg, a_cn_reg;
    logic [31:0] a_am_reg, a_bm_reg, a_cm_reg;
    logic [31:0] raw_a, raw_b, raw_c;

    assign raw_a = coef.coef_a;
    assign raw_b = coef.coef_b;
    assign raw_c = coef.coef_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_an_reg <= raw_a[31];
        a_bn_reg <= raw_b[31];
        a_cn_reg <= raw_c[31];
        a_am_reg <= raw_a[31] ? (~raw_a + 32'd1) : raw_a;
        a_bm_reg <= raw_b[31] ? (~raw_b + 32'd1) : raw_b;
        a_cm_reg <= raw_c[31] ? (~raw_c + 32'd1) : raw_c;
    end

    // ------------------------------------------------------------------
    // Stage B: b^2 and a*c on the magnitudes.
    // ------------------------------------------------------------------
    logic        b_valid_reg;
    logic        b_an_reg, b_bn_reg, b_cn_reg;
    logic [31:0] b_am_reg, b_bm_reg, b_cm_reg;
    logic [63:0] b_bsq_reg, b_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_an_reg  <= a_an_reg;
        b_bn_reg  <= a_bn_reg;
        b_cn_reg  <= a_cn_reg;
        b_am_reg  <= a_am_reg;
        b_bm_reg  <= a_bm_reg;
        b_cm_reg  <= a_cm_reg;
        b_bsq_reg <= a_bm_reg * a_bm_reg;
        b_p_reg   <= a_am_reg * a_cm_reg;
    end

    // ------------------------------------------------------------------
    // Stage C: discriminant and equation class.
    // ------------------------------------------------------------------
    logic [65:0] bsq_ext, p4, disc;
    logic        disc_neg;
    class_t      cls;

    always_comb
    begin
        bsq_ext  = {2'b00, b_bsq_reg};
        p4       = {b_p_reg, 2'b00};
        disc_neg = 1'b0;
        if (b_p_reg != 64'd0 && b_an_reg != b_cn_reg)
        begin
            disc = bsq_ext + p4;
        end
        else if (p4 > bsq_ext)
        begin
            disc     = 66'd0;
            disc_neg = 1'b1;
        end
        else
        begin
            disc = bsq_ext - p4;
        end

        if (b_am_reg == 32'd0)
        begin
            if (b_bm_reg == 32'd0)
            begin
                cls = (b_cm_reg == 32'd0) ? CL_ANY : CL_NONE;
            end
            else
            begin
                cls = CL_LIN;
            end
        end
        else if (disc_neg)
        begin
            cls = CL_NONE;
        end
        else if (disc == 66'd0)
        begin
            cls = CL_ONE;
        end
        else
        begin
            cls = CL_TWO;
        end
    end

    // ------------------------------------------------------------------
    // Square root pipeline: one root digit per stage.
    // ------------------------------------------------------------------
    logic                  sq_valid_reg [0:SQ_STEPS];
    sq_meta_t              sq_meta_reg  [0:SQ_STEPS];
    logic [DISC_W-1:0]     sq_d_reg     [0:SQ_STEPS];
    logic [SQ_REM_W-1:0]   sq_rem_reg   [0:SQ_STEPS];
    logic [SQ_STEPS-1:0]   sq_root_reg  [0:SQ_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else
        begin
            sq_valid_reg[0] <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_meta_reg[0] <= '{cls: cls, an: b_an_reg, bn: b_bn_reg, cn: b_cn_reg,
                            am: b_am_reg, bm: b_bm_reg, cm: b_cm_reg};
        sq_d_reg[0]    <= {{(DISC_W-66){1'b0}}, disc};
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
    end

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++)
        begin : g_sq
            logic [SQ_REM_W-1:0] rem_sh, trial;
            logic                take;

            // Bring down the next two bits and try the next root digit.
            always_comb
            begin
                rem_sh = {sq_rem_reg[k][SQ_REM_W-3:0], sq_d_reg[k][DISC_W-1 -: 2]};
                trial  = {{(SQ_REM_W-SQ_STEPS-2){1'b0}}, sq_root_reg[k], 2'b01};
                take   = (rem_sh >= trial);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_valid_reg[k+1] <= 1'b0;
                end
                else
                begin
                    sq_valid_reg[k+1] <= sq_valid_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                sq_meta_reg[k+1] <= sq_meta_reg[k];
                sq_d_reg[k+1]    <= {sq_d_reg[k][DISC_W-3:0], 2'b00};
                sq_rem_reg[k+1]  <= take ? (rem_sh - trial) : rem_sh;
                sq_root_reg[k+1] <= {sq_root_reg[k][SQ_STEPS-2:0], take};
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage E: numerators, denominator and divider setup.
    // ------------------------------------------------------------------
    sq_meta_t                 em;
    logic signed [36:0]       mb, n1, n2;
    logic [36:0]              n1_abs, n2_abs;
    logic [NMAG_W-1:0]        nmag [0:1];
    logic                     nneg [0:1];
    logic [DMAG_W-1:0]        dmag;
    logic                     dneg;
    logic [NW-1:0]            num  [0:1];
    logic [DMAG_W-1:0]        hi   [0:1];

    always_comb
    begin
        em     = sq_meta_reg[SQ_STEPS];
        mb     = em.bn ? $signed({5'd0, em.bm}) : -$signed({5'd0, em.bm});
        n1     = mb + $signed({2'b00, sq_root_reg[SQ_STEPS]});
        n2     = mb - $signed({2'b00, sq_root_reg[SQ_STEPS]});
        n1_abs = n1[36] ? -n1 : n1;
        n2_abs = n2[36] ? -n2 : n2;
        nmag[0] = '0;
        nmag[1] = '0;
        nneg[0] = 1'b0;
        nneg[1] = 1'b0;
        dmag    = {em.am, 1'b0};
        dneg    = em.an;
        case (em.cls)
            CL_LIN:
            begin
                nmag[0] = {3'b000, em.cm};
                nneg[0] = !em.cn;
                dmag    = {1'b0, em.bm};
                dneg    = em.bn;
            end
            CL_ONE:
            begin
                nmag[0] = {3'b000, em.bm};
                nneg[0] = !em.bn;
            end
            CL_TWO:
            begin
                nmag[0] = n1_abs[NMAG_W-1:0];
                nneg[0] = n1[36];
                nmag[1] = n2_abs[NMAG_W-1:0];
                nneg[1] = n2[36];
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < 2; i++)
        begin
            num[i] = {nmag[i], {FRAC_BITS{1'b0}}};
            hi[i]  = {{(DMAG_W-HW){1'b0}}, num[i][NW-1:Q_BITS]};
        end
    end

    // ------------------------------------------------------------------
    // Division pipeline: one quotient bit per stage, two lanes.
    // ------------------------------------------------------------------
    logic                 dv_valid_reg [0:Q_BITS];
    class_t               dv_cls_reg   [0:Q_BITS];
    logic [DMAG_W-1:0]    dv_d_reg     [0:Q_BITS];
    logic [DMAG_W-1:0]    dv_rem_reg   [0:Q_BITS][0:1];
    logic [Q_BITS-1:0]    dv_low_reg   [0:Q_BITS][0:1];
    logic [Q_BITS-1:0]    dv_q_reg     [0:Q_BITS][0:1];
    logic                 dv_neg_reg   [0:Q_BITS][0:1];
    logic                 dv_pov_reg   [0:Q_BITS][0:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[0] <= sq_valid_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        dv_cls_reg[0] <= em.cls;
        dv_d_reg[0]   <= dmag;
        for (int i = 0; i < 2; i++)
        begin
            dv_rem_reg[0][i] <= hi[i];
            dv_low_reg[0][i] <= num[i][Q_BITS-1:0];
            dv_q_reg[0][i]   <= '0;
            dv_neg_reg[0][i] <= nneg[i] ^ dneg;
            dv_pov_reg[0][i] <= (hi[i] >= dmag);
        end
    end

    genvar j, ln;
    generate
        for (j = 0; j < Q_BITS; j++)
        begin : g_dv
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_valid_reg[j+1] <= 1'b0;
                end
                else
                begin
                    dv_valid_reg[j+1] <= dv_valid_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                dv_cls_reg[j+1] <= dv_cls_reg[j];
                dv_d_reg[j+1]   <= dv_d_reg[j];
            end

            for (ln = 0; ln < 2; ln++)
            begin : g_lane
                logic [DMAG_W:0] rsh;
                logic            take;

                // Shift in the next dividend bit and subtract if it fits.
                always_comb
                begin
                    rsh  = {dv_rem_reg[j][ln], dv_low_reg[j][ln][Q_BITS-1]};
                    take = (rsh >= {1'b0, dv_d_reg[j]});
                end

                always_ff @(posedge clk)
                begin
                    dv_rem_reg[j+1][ln] <= take ? DMAG_W'(rsh - {1'b0, dv_d_reg[j]})
                                                : rsh[DMAG_W-1:0];
                    dv_low_reg[j+1][ln] <= {dv_low_reg[j][ln][Q_BITS-2:0], 1'b0};
                    dv_q_reg[j+1][ln]   <= {dv_q_reg[j][ln][Q_BITS-2:0], take};
                    dv_neg_reg[j+1][ln] <= dv_neg_reg[j][ln];
                    dv_pov_reg[j+1][ln] <= dv_pov_reg[j][ln];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output stage: sign, saturation and result assembly.
    // ------------------------------------------------------------------
    logic        done_reg;
    result_t     result_reg, result_next;
    logic [32:0] s1, s2;

    always_comb
    begin
        s1 = sat_root(dv_neg_reg[Q_BITS][0], dv_pov_reg[Q_BITS][0],
                      dv_q_reg[Q_BITS][0]);
        s2 = sat_root(dv_neg_reg[Q_BITS][1], dv_pov_reg[Q_BITS][1],
                      dv_q_reg[Q_BITS][1]);
        result_next = '0;
        case (dv_cls_reg[Q_BITS]) inside
            CL_ANY:
            begin
                result_next.root_count = CNT_ANY;
            end
            CL_LIN, CL_ONE:
            begin
                result_next.root_count = CNT_ONE;
                result_next.first_root = s1[31:0];
                result_next.overflow   = s1[32];
            end
            CL_TWO:
            begin
                result_next.root_count  = CNT_TWO;
                result_next.first_root  = s1[31:0];
                result_next.second_root = s2[31:0];
                result_next.overflow    = s1[32] | s2[32];
            end
            default:
            begin
                result_next.root_count = CNT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid_reg[Q_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quadratic root solver. A directed table covers
// the special equation classes and extreme coefficients; random triples
// follow. Each result is matched to a typed value or an in-bench root calculator.
// ----------------------------------------------------------------------------
module tb;
    import qrs_pkg::*;

    localparam int FB = 16;
    localparam int IDLE_LIMIT = 400;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    coef_t   coef;
    logic    done;
    result_t result;

    result_t roots_due[$];
    int      errors;
    int      idle_cycles;
    bit      feeding;

    quadratic_root_solver #(.FRAC_BITS(FB)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coef(coef), .done(done), .result(result)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end
    always #6 clk = ~clk;

    // Signed quotient (num << FB) / den, truncated, then saturated.
    function automatic logic signed [31:0] scaled_quotient(
        input logic signed [71:0] num, input logic signed [71:0] den,
        inout logic ovf);
        logic signed [71:0] q;
        if (den == 0)
            return 0;
        q = (num <<< FB) / den;
        if (q > 72'sh7FFFFFFF)
        begin
            ovf = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (q < -72'sh80000000)
        begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    // Floor of the square root of a nonnegative value below 2^68.
    function automatic logic [71:0] floor_sqrt(input logic [71:0] d);
        logic [71:0] r;
        logic [71:0] t;
        r = 0;
        for (int k = 34; k >= 0; k--)
        begin
            t = r | (72'd1 << k);
            if (t * t <= d)
                r = t;
        end
        return r;
    endfunction

    // Expected result for one coefficient triple.
    function automatic result_t solve_roots(input coef_t c);
        result_t r;
        logic signed [71:0] a, b, k, disc, s;
        logic ovf;
        a = c.coef_a;
        b = c.coef_b;
        k = c.coef_c;
        ovf = 1'b0;
        r = '0;
        if (a == 0)
        begin
            if (b == 0)
                r.root_count = (k == 0) ? CNT_ANY : CNT_NONE;
            else
            begin
                r.root_count = CNT_ONE;
                r.first_root = scaled_quotient(-k, b, ovf);
            end
        end
        else
        begin
            disc = b * b - 4 * a * k;
            if (disc < 0)
                r.root_count = CNT_NONE;
            else if (disc == 0)
            begin
                r.root_count = CNT_ONE;
                r.first_root = scaled_quotient(-b, 2 * a, ovf);
            end
            else
            begin
                s = floor_sqrt(disc);
                r.root_count = CNT_TWO;
                r.first_root = scaled_quotient(-b + s, 2 * a, ovf);
                r.second_root = scaled_quotient(-b - s, 2 * a, ovf);
            end
        end
        r.overflow = ovf;
        return r;
    endfunction

    // Random coefficient with a spread of magnitudes.
    function automatic logic signed [31:0] rand_coef();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $signed(v) >>> $urandom_range(8, 30);
            2: return v[31] ? -32'sd1 << FB : 32'sd1 << FB;
            default: return v;
        endcase
    endfunction

    // Hold start for one transfer, then drop it for a random gap that may be zero.
    task automatic send_triple(input coef_t c, input bit typed, input result_t want);
        int gap;
        coef <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        roots_due.push_back(typed ? want : solve_roots(c));
        @(negedge clk);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Directed rows: coefficients, and whether the result is typed in.
    typedef struct {
        coef_t   c;
        bit      typed;
        result_t want;
    } row_t;

    row_t rows[$];

    // Result checking at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (roots_due.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                result_t w;
                w = roots_due.pop_front();
                if (result.root_count !== w.root_count)
                begin
                    $error("root_count exp %0d got %0d", w.root_count, result.root_count);
                    errors++;
                end
                if (result.first_root !== w.first_root)
                begin
                    $error("first_root exp %0d got %0d", w.first_root, result.first_root);
                    errors++;
                end
                if (result.second_root !== w.second_root)
                begin
                    $error("second_root exp %0d got %0d", w.second_root,
                           result.second_root);
                    errors++;
                end
                if (result.overflow !== w.overflow)
                begin
                    $error("overflow exp %0d got %0d", w.overflow, result.overflow);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((start && !busy && feeding) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic row_t mk(input int a, input int b, input int c,
                                input bit typed, input result_t w);
        row_t r;
        r.c.coef_a = a;
        r.c.coef_b = b;
        r.c.coef_c = c;
        r.typed = typed;
        r.want = w;
        return r;
    endfunction

    initial
    begin
        localparam int ONE = 1 << FB;
        coef_t c;
        errors = 0;
        idle_cycles = 0;
        feeding = 1'b0;
        start = 1'b0;
        coef = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        feeding = 1'b1;

        // Degenerate, inconsistent, negative discriminant: typed results.
        rows.push_back(mk(0, 0, 0, 1, '{CNT_ANY, 0, 0, 1'b0}));
        rows.push_back(mk(0, 0, ONE, 1, '{CNT_NONE, 0, 0, 1'b0}));
        rows.push_back(mk(0, 0, 32'h80000000, 1, '{CNT_NONE, 0, 0, 1'b0}));
        rows.push_back(mk(ONE, 0, ONE, 1, '{CNT_NONE, 0, 0, 1'b0}));
        // Linear: x + 2 = 0, and a saturating one.
        rows.push_back(mk(0, ONE, 2 * ONE, 1, '{CNT_ONE, -2 * ONE, 0, 1'b0}));
        rows.push_back(mk(0, 1, 32'h7FFFFFFF, 1,
                          '{CNT_ONE, 32'sh80000000, 0, 1'b1}));
        // Zero discriminant: x^2 - 2x + 1.
        rows.push_back(mk(ONE, -2 * ONE, ONE, 1, '{CNT_ONE, ONE, 0, 1'b0}));
        // Two roots: x^2 - 1, for both signs of a.
        rows.push_back(mk(ONE, 0, -ONE, 1, '{CNT_TWO, ONE, -ONE, 1'b0}));
        rows.push_back(mk(-ONE, 0, ONE, 1, '{CNT_TWO, -ONE, ONE, 1'b0}));
        // Field extremes, checked by the predictor.
        rows.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 0, '0));
        rows.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, '0));
        rows.push_back(mk(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, '0));
        rows.push_back(mk(1, 32'h80000000, 32'h80000000, 0, '0));
        rows.push_back(mk(1, 32'h7FFFFFFF, -1, 0, '0));
        rows.push_back(mk(-1, 1, 32'h7FFFFFFF, 0, '0));
        rows.push_back(mk(0, -1, 32'h80000000, 0, '0));
        rows.push_back(mk(0, 32'h80000000, 1, 0, '0));
        rows.push_back(mk(32'hFFFFFFFF, 0, 0, 0, '0));

        foreach (rows[i])
            send_triple(rows[i].c, rows[i].typed, rows[i].want);

        // Random triples; a share is built from chosen roots to hit zero discriminants.
        repeat (1300)
        begin
            c.coef_a = rand_coef();
            c.coef_b = rand_coef();
            c.coef_c = rand_coef();
            if ($urandom_range(0, 7) == 0)
            begin
                int r0;
                r0 = $signed($urandom_range(0, 512)) - 256;
                c.coef_a = ONE;
                c.coef_b = -2 * r0 * ONE;
                c.coef_c = r0 * r0 * ONE;
            end
            send_triple(c, 1'b0, '0);
        end
        start <= 1'b0;
        feeding = 1'b0;

        // Drain, then allow the pipeline latency to pass.
        while (roots_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
